### rtl/dsm_pkg.sv
// Package for the digit-sum multiple counter: constants, types and modular helpers.
`default_nettype none
package dsm_pkg;

  localparam int unsigned DEF_MAX_DIVISOR = 128;
  localparam int unsigned CNT_W           = 30;
  localparam int unsigned DIV_W           = 8;
  localparam int unsigned DIGIT_W         = 4;
  localparam logic [CNT_W-1:0] MOD_P      = 30'd1000000007;
  localparam logic [DIGIT_W-1:0] DIGITS_PER_STEP = 4'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SUM,
    ST_SUM_WAIT,
    ST_QMUL,
    ST_MAIN,
    ST_MAIN_WAIT,
    ST_FINISH
  } dsm_state_e;

  typedef struct packed {
    logic load;
    logic cnt_clr;
    logic setup_step;
    logic sum_issue;
    logic qmul_step;
    logic main_issue;
    logic finish;
    logic emit;
  } dsm_cmd_t;

  typedef struct packed {
    logic setup_done;
    logic sum_last;
    logic qmul_done;
    logic main_last;
    logic out_free;
  } dsm_sts_t;

  function automatic logic [CNT_W-1:0] mod_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MOD_P}) s = s - {1'b0, MOD_P};
    return s[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] mod_sub(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    if (a >= b) s = {1'b0, a} - {1'b0, b};
    else s = {1'b0, a} + {1'b0, MOD_P} - {1'b0, b};
    return s[CNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/dsm_ram.sv
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module dsm_ram #(
  parameter int unsigned Width = 30,
  parameter int unsigned Depth = 128,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [AddrW-1:0]         wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic [AddrW-1:0]         rd_addr_a_i,
  input  wire logic [AddrW-1:0]         rd_addr_b_i,
  output logic      [Width-1:0]         rd_data_a_o,
  output logic      [Width-1:0]         rd_data_b_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_addr_i] <= wr_data_i;
    rd_data_a_o <= mem_q[rd_addr_a_i];
    rd_data_b_o <= mem_q[rd_addr_b_i];
  end
endmodule
`default_nettype wire

### rtl/dsm_ctrl.sv
// Controller state machine sequencing the per-digit passes.
`default_nettype none
module dsm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_last_i,
  output logic                   in_ready_o,
  input  wire dsm_pkg::dsm_sts_t sts_i,
  output dsm_pkg::dsm_cmd_t      cmd_o
);
  dsm_pkg::dsm_state_e state_q, state_d;
  logic last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsm_pkg::ST_IDLE;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    last_d     = last_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      dsm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          last_d        = in_last_i;
          state_d       = dsm_pkg::ST_SETUP;
        end
      end
      dsm_pkg::ST_SETUP: begin
        cmd_o.setup_step = 1'b1;
        if (sts_i.setup_done) state_d = dsm_pkg::ST_SUM;
      end
      dsm_pkg::ST_SUM: begin
        cmd_o.sum_issue = 1'b1;
        if (sts_i.sum_last) state_d = dsm_pkg::ST_SUM_WAIT;
      end
      dsm_pkg::ST_SUM_WAIT: begin
        // last read of the sum pass lands here
        cmd_o.cnt_clr = 1'b1;
        state_d       = dsm_pkg::ST_QMUL;
      end
      dsm_pkg::ST_QMUL: begin
        cmd_o.qmul_step = 1'b1;
        if (sts_i.qmul_done) state_d = dsm_pkg::ST_MAIN;
      end
      dsm_pkg::ST_MAIN: begin
        cmd_o.main_issue = 1'b1;
        if (sts_i.main_last) state_d = dsm_pkg::ST_MAIN_WAIT;
      end
      dsm_pkg::ST_MAIN_WAIT: begin
        state_d = dsm_pkg::ST_FINISH;
      end
      dsm_pkg::ST_FINISH: begin
        // hold the final digit until the output register is free
        if (!last_q || sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          cmd_o.emit   = last_q;
          state_d      = dsm_pkg::ST_IDLE;
        end
      end
      default: state_d = dsm_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### rtl/dsm_dp.sv
// Datapath: residue count table banks, window and total sums, result register.
`default_nettype none
module dsm_dp #(
  parameter int unsigned MaxDivisor = dsm_pkg::DEF_MAX_DIVISOR
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [dsm_pkg::DIV_W-1:0]     divisor_i,
  input  wire logic [dsm_pkg::DIGIT_W-1:0]   digit_i,
  input  wire dsm_pkg::dsm_cmd_t             cmd_i,
  output dsm_pkg::dsm_sts_t                  sts_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [dsm_pkg::CNT_W-1:0]          out_count_o
);
  localparam int unsigned AW = (MaxDivisor > 1) ? $clog2(MaxDivisor) : 1;
  localparam int unsigned DW = $clog2(MaxDivisor + 1);
  localparam int unsigned XW = DW + 5;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned NW = dsm_pkg::CNT_W;
  localparam int unsigned GW = dsm_pkg::DIGIT_W;

  logic [DW-1:0] d_q;
  logic [AW-1:0] e_q, eq_q;
  logic [GW-1:0] tr_q, qc_q, cr_q, cq_q;
  logic [CW-1:0] cnt_q, r1_q;
  logic [AW-1:0] b1_q;
  logic          sum1_q, main1_q, sel_q;
  logic [NW-1:0] tot_q, win_q, qt_q, first_q;
  logic [MaxDivisor-1:0] val_q [2];
  logic          out_valid_q;
  logic [NW-1:0] out_q;

  logic [XW-1:0] dx, ex, cx, wx, r1x, thr, eff, divx, sx, relx;
  logic [AW-1:0] rd_a_addr, rd_b_addr, eq_new;
  logic [NW-1:0] ram_a0, ram_b0, ram_a1, ram_b1, a_raw, a_m, b_m;
  logic [NW-1:0] win_new, nxt, eqx;
  logic [GW:0]   eqadd;
  logic          wr_en;
  logic [NW-1:0] wr_data;

  assign divx = XW'(divisor_i);
  assign eff  = (divx == '0) ? XW'(1)
              : ((divx > XW'(MaxDivisor)) ? XW'(MaxDivisor) : divx);
  assign dx   = XW'(d_q);
  assign ex   = XW'(e_q);
  assign cx   = XW'(cnt_q);
  assign wx   = XW'(tr_q);
  assign r1x  = XW'(r1_q);
  assign thr  = dx - wx;

  assign rd_a_addr = cnt_q[AW-1:0];
  assign rd_b_addr = (cx >= wx) ? AW'(cx - wx) : AW'(cx + dx - wx);

  dsm_ram #(.Width(NW), .Depth(MaxDivisor)) u_bank0 (
    .clk_i, .wr_en_i(wr_en & sel_q), .wr_addr_i(r1_q[AW-1:0]), .wr_data_i(wr_data),
    .rd_addr_a_i(rd_a_addr), .rd_addr_b_i(rd_b_addr),
    .rd_data_a_o(ram_a0), .rd_data_b_o(ram_b0)
  );

  dsm_ram #(.Width(NW), .Depth(MaxDivisor)) u_bank1 (
    .clk_i, .wr_en_i(wr_en & ~sel_q), .wr_addr_i(r1_q[AW-1:0]), .wr_data_i(wr_data),
    .rd_addr_a_i(rd_a_addr), .rd_addr_b_i(rd_b_addr),
    .rd_data_a_o(ram_a1), .rd_data_b_o(ram_b1)
  );

  // entries never written since the last clear read as zero
  assign a_raw = sel_q ? ram_a1 : ram_a0;
  assign a_m   = val_q[sel_q][r1_q[AW-1:0]] ? a_raw : '0;
  assign b_m   = val_q[sel_q][b1_q] ? (sel_q ? ram_b1 : ram_b0) : '0;

  // equal prefix adds one for every smaller digit landing on this residue
  assign relx    = (r1x >= ex) ? (r1x - ex) : (r1x + dx - ex);
  assign eqadd   = {1'b0, cq_q} + {{GW{1'b0}}, (relx < XW'(cr_q))};
  assign eqx     = dsm_pkg::mod_add(qt_q, NW'(eqadd));
  assign win_new = dsm_pkg::mod_sub(dsm_pkg::mod_add(win_q, a_m), b_m);
  assign nxt     = dsm_pkg::mod_add(win_new, eqx);

  assign wr_en   = main1_q;
  assign wr_data = (r1x < dx) ? nxt : a_m;

  assign sx     = ex + XW'(cr_q);
  assign eq_new = (sx >= dx) ? AW'(sx - dx) : AW'(sx);

  assign sts_o.setup_done = (ex < dx) && (wx < dx) && (XW'(cr_q) < dx);
  assign sts_o.sum_last   = (cx == dx - XW'(1));
  assign sts_o.qmul_done  = (qc_q == '0);
  assign sts_o.main_last  = (cx == XW'(MaxDivisor - 1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_count_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q[0]    <= '0;
      val_q[1]    <= '0;
      eq_q        <= '0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
      sum1_q      <= 1'b0;
      main1_q     <= 1'b0;
      cnt_q       <= '0;
    end else begin
      sum1_q  <= cmd_i.sum_issue;
      main1_q <= cmd_i.main_issue;
      if (cmd_i.cnt_clr) cnt_q <= '0;
      else if (cmd_i.sum_issue || cmd_i.main_issue) cnt_q <= cnt_q + CW'(1);
      if (main1_q) val_q[~sel_q][r1_q[AW-1:0]] <= 1'b1;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.finish) begin
        sel_q <= ~sel_q;
        if (cmd_i.emit) begin
          val_q[0]    <= '0;
          val_q[1]    <= '0;
          eq_q        <= '0;
          out_valid_q <= 1'b1;
        end else begin
          eq_q <= eq_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r1_q <= cnt_q;
    b1_q <= rd_b_addr;
    if (cmd_i.load) begin
      d_q     <= DW'(eff);
      e_q     <= eq_q;
      tr_q    <= dsm_pkg::DIGITS_PER_STEP;
      qc_q    <= '0;
      cr_q    <= digit_i;
      cq_q    <= '0;
      tot_q   <= '0;
      win_q   <= '0;
      qt_q    <= '0;
      first_q <= '0;
    end
    if (cmd_i.setup_step) begin
      // peel off one divisor per cycle from each small operand
      if (ex >= dx) e_q <= AW'(ex - dx);
      if (wx >= dx) begin
        tr_q <= GW'(wx - dx);
        qc_q <= qc_q + GW'(1);
      end
      if (XW'(cr_q) >= dx) begin
        cr_q <= GW'(XW'(cr_q) - dx);
        cq_q <= cq_q + GW'(1);
      end
    end
    if (sum1_q) begin
      tot_q <= dsm_pkg::mod_add(tot_q, a_m);
      if (r1x >= thr) win_q <= dsm_pkg::mod_add(win_q, a_m);
    end
    if (cmd_i.qmul_step && (qc_q != '0)) begin
      qt_q <= dsm_pkg::mod_add(qt_q, tot_q);
      qc_q <= qc_q - GW'(1);
    end
    if (main1_q && (r1x < dx)) begin
      win_q <= win_new;
      if (r1_q == '0) first_q <= nxt;
    end
    if (cmd_i.emit) begin
      out_q <= dsm_pkg::mod_sub(
                 dsm_pkg::mod_add(first_q, NW'(eq_new == '0)), NW'(1));
    end
  end

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.load) |-> (d_q != '0))
    else $error("effective divisor is zero");
  a_sums_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    main1_q |-> (win_q < dsm_pkg::MOD_P) && (qt_q < dsm_pkg::MOD_P))
    else $error("running sum not reduced");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");
  a_one_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sum1_q && main1_q))
    else $error("sum and main passes overlap");

endmodule
`default_nettype wire

### rtl/digit_sum_multiple_counter.sv
// Top level of the digit-sum multiple counter.
// Feed the decimal digits of a bound N, most significant first, with tlast on the
// least significant one; the block returns one transaction holding how many of
// 1..N have a digit sum divisible by the divisor register, modulo 1000000007.
// Each digit runs a setup that reduces the old residue, the step of ten and the
// digit by the effective divisor D, a sum pass over the first D entries of the
// residue table, a multiply of their total by the quotient 10 / D, and a sweep
// over all MAX_DIVISOR entries of the residue table, one entry per cycle through
// a two-read-port RAM. The last digit also holds in its final state while an
// earlier count is still waiting on the output.
// A divisor of zero acts as one, and one above MAX_DIVISOR acts as MAX_DIVISOR.
// Write the divisor only while no digit is in flight.
`default_nettype none
module digit_sum_multiple_counter #(
  parameter int unsigned MAX_DIVISOR = dsm_pkg::DEF_MAX_DIVISOR
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,     // divisor
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // [3:0] digit, [7:4] zero
  input  wire logic        s_axis_tlast_i,  // last_digit
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o   // [29:0] count, [31:30] zero
);
  logic [dsm_pkg::DIV_W-1:0] divisor_q;
  dsm_pkg::dsm_cmd_t         cmd;
  dsm_pkg::dsm_sts_t         sts;
  logic [dsm_pkg::CNT_W-1:0] count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) divisor_q <= dsm_pkg::DIV_W'(1);
    else if (cfg_we_i) divisor_q <= cfg_wdata_i;
  end

  dsm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_last_i(s_axis_tlast_i),
    .in_ready_o(s_axis_tready_o), .sts_i(sts), .cmd_o(cmd)
  );

  dsm_dp #(.MaxDivisor(MAX_DIVISOR)) u_dp (
    .clk_i, .rst_ni,
    .divisor_i(divisor_q), .digit_i(s_axis_tdata_i[3:0]),
    .cmd_i(cmd), .sts_o(sts),
    .out_ready_i(m_axis_tready_i), .out_valid_o(m_axis_tvalid_o), .out_count_o(count)
  );

  assign m_axis_tdata_o = {2'b00, count};
endmodule
`default_nettype wire
